### rtl/coalescing_interval_set_top_defines.svh
// assertion helpers used by the interval set controller
`ifndef COALESCING_INTERVAL_SET_TOP_DEFINES_SVH
`define COALESCING_INTERVAL_SET_TOP_DEFINES_SVH

// same-cycle implication, sampled on clock, quiet during reset
`define CIS_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define CIS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### rtl/cis_pkg.sv
`default_nettype none
package cis_pkg;

   localparam int NUM_BLOCK_REGS = 5;
   localparam int DEF_TABLE_DEPTH = 64;
   localparam int DEF_BLOCKS = 5;
   localparam int CSR_AW = 5;

   localparam logic [1:0] OP_MARK = 2'd0;
   localparam logic [1:0] OP_CONTAINS = 2'd1;
   localparam logic [1:0] OP_CONTIG = 2'd2;
   localparam logic [1:0] OP_CLEAR = 2'd3;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_INVALID_CTX = 3'd1;
   localparam logic [2:0] ST_OUT_OF_RANGE = 3'd2;
   localparam logic [2:0] ST_CAPACITY = 3'd3;
   localparam logic [2:0] ST_UNMATERIALIZED = 3'd4;

   localparam logic [2:0] REG_CONTEXT_VALID = 3'd0;
   localparam logic [2:0] REG_MAX_INTERVALS = 3'd1;
   localparam logic [2:0] REG_BLOCK_SIZE_0 = 3'd2;
   localparam logic [2:0] REG_BLOCK_SIZE_4 = 3'd6;

   typedef struct packed {
      logic        context_valid;
      logic [6:0]  max_intervals;
      logic [NUM_BLOCK_REGS-1:0][31:0] block_size;
   } cfg_type;

   typedef struct packed {
      logic [2:0]  blk;
      logic [31:0] first;
      logic [31:0] last;
   } entry_type;

   function automatic logic [31:0] block_size_sel(input cfg_type cfg, input logic [2:0] b);
      logic [31:0] r;
      r = '0;
      for (int j = 0; j < NUM_BLOCK_REGS; j++) begin
         if (b == 3'(j)) begin
            r = cfg.block_size[j];
         end
      end
      return r;
   endfunction

endpackage
`default_nettype wire

### rtl/cis_if.sv
`default_nettype none
interface cis_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [2:0]  block_index;
   logic [31:0] range_offset;
   logic [31:0] range_size;
   modport source(output valid, opcode, block_index, range_offset, range_size, input ready);
   modport sink(input valid, opcode, block_index, range_offset, range_size, output ready);
endinterface

interface cis_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic        hit;
   logic [31:0] contiguous_bytes;
   modport source(output valid, status, hit, contiguous_bytes, input ready);
   modport sink(input valid, status, hit, contiguous_bytes, output ready);
endinterface
`default_nettype wire

### rtl/cis_csr.sv
`default_nettype none
module cis_csr
   import cis_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CSR_AW-1:0] csr_paddr,
   input  wire logic [31:0]       csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready,
   output cfg_type                cfg
);
   cfg_type     cfg_ff, cfg_in;
   logic [2:0]  idx;
   logic        wr;

   assign idx = csr_paddr[CSR_AW-1:2];
   assign wr = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         if (idx == REG_CONTEXT_VALID) begin
            cfg_in.context_valid = csr_pwdata[0];
         end else if (idx == REG_MAX_INTERVALS) begin
            cfg_in.max_intervals = csr_pwdata[6:0];
         end else if (idx >= REG_BLOCK_SIZE_0 && idx <= REG_BLOCK_SIZE_4) begin
            for (int j = 0; j < NUM_BLOCK_REGS; j++) begin
               if (idx == REG_BLOCK_SIZE_0 + 3'(j)) begin
                  cfg_in.block_size[j] = csr_pwdata;
               end
            end
         end
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (idx == REG_CONTEXT_VALID) begin
         csr_prdata = {31'b0, cfg_ff.context_valid};
      end else if (idx == REG_MAX_INTERVALS) begin
         csr_prdata = {25'b0, cfg_ff.max_intervals};
      end else if (idx >= REG_BLOCK_SIZE_0 && idx <= REG_BLOCK_SIZE_4) begin
         csr_prdata = block_size_sel(cfg_ff, idx - REG_BLOCK_SIZE_0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.context_valid <= 1'b0;
         cfg_ff.max_intervals <= 7'd64;
         cfg_ff.block_size <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end
endmodule
`default_nettype wire

### rtl/cis_table.sv
`default_nettype none
module cis_table
   import cis_pkg::*;
#(
   parameter int DEPTH = DEF_TABLE_DEPTH,
   parameter int AW = 6
) (
   input  wire logic          clock,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output entry_type          rd_data,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire entry_type     wr_data
);
   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end
endmodule
`default_nettype wire

### rtl/cis_ctrl.sv
`default_nettype none
`include "coalescing_interval_set_top_defines.svh"
module cis_ctrl
   import cis_pkg::*;
#(
   parameter int DEPTH = DEF_TABLE_DEPTH,
   parameter int BLOCKS = DEF_BLOCKS,
   parameter int AW = 6,
   parameter int CW = 7
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   cis_req_if.sink      req_if,
   cis_rsp_if.source    rsp_if,
   output logic         rd_en,
   output logic [AW-1:0] rd_addr,
   input  wire entry_type rd_data,
   output logic         wr_en,
   output logic [AW-1:0] wr_addr,
   output entry_type    wr_data
);
   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_SCAN_RD = 4'd1;
   localparam logic [3:0] S_SCAN_EV = 4'd2;
   localparam logic [3:0] S_DECIDE = 4'd3;
   localparam logic [3:0] S_DN_RD = 4'd4;
   localparam logic [3:0] S_DN_WR = 4'd5;
   localparam logic [3:0] S_UP_RD = 4'd6;
   localparam logic [3:0] S_UP_WR = 4'd7;
   localparam logic [3:0] S_RESP = 4'd8;

   logic [3:0]    state_ff, state_in;
   logic [CW-1:0] total_ff, total_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    op_ff, op_in;
   logic [2:0]    blk_ff, blk_in;
   logic [31:0]   off_ff, off_in;
   logic [31:0]   size_ff, size_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] first_ff, first_in;
   logic [CW-1:0] merged_ff, merged_in;
   logic          phase_a_ff, phase_a_in;
   logic [31:0]   mb_ff, mb_in;
   logic [31:0]   me_ff, me_in;
   logic          found_ff, found_in;
   logic [31:0]   cov_end_ff, cov_end_in;
   logic [2:0]    res_status_ff, res_status_in;
   logic          res_hit_ff, res_hit_in;
   logic [31:0]   res_bytes_ff, res_bytes_in;
   logic [2:0]    out_status_ff, out_status_in;
   logic          out_hit_ff, out_hit_in;
   logic [31:0]   out_bytes_ff, out_bytes_in;

   logic          accept;
   logic [31:0]   req_bsize;
   logic          req_blk_bad;
   logic [CW:0]   src_idx;
   logic [CW-1:0] first_eff;
   logic [CW-1:0] k_cnt;

   assign req_if.ready = (state_ff == S_IDLE);
   assign accept = req_if.valid && req_if.ready;
   assign req_bsize = block_size_sel(cfg, req_if.block_index);
   assign req_blk_bad = 32'(req_if.block_index) >= BLOCKS;
   assign k_cnt = merged_ff - CW'(1);
   assign src_idx = {1'b0, idx_ff} + {1'b0, k_cnt};
   assign first_eff = phase_a_ff ? idx_ff : first_ff;

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.status = out_status_ff;
   assign rsp_if.hit = out_hit_ff;
   assign rsp_if.contiguous_bytes = out_bytes_ff;

   always_comb begin
      state_in = state_ff;
      total_in = total_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      op_in = op_ff;
      blk_in = blk_ff;
      off_in = off_ff;
      size_in = size_ff;
      idx_in = idx_ff;
      first_in = first_ff;
      merged_in = merged_ff;
      phase_a_in = phase_a_ff;
      mb_in = mb_ff;
      me_in = me_ff;
      found_in = found_ff;
      cov_end_in = cov_end_ff;
      res_status_in = res_status_ff;
      res_hit_in = res_hit_ff;
      res_bytes_in = res_bytes_ff;
      out_status_in = out_status_ff;
      out_hit_in = out_hit_ff;
      out_bytes_in = out_bytes_ff;
      rd_en = 1'b0;
      rd_addr = idx_ff[AW-1:0];
      wr_en = 1'b0;
      wr_addr = idx_ff[AW-1:0];
      wr_data = rd_data;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in = req_if.opcode;
               blk_in = req_if.block_index;
               off_in = req_if.range_offset;
               size_in = req_if.range_size;
               idx_in = '0;
               merged_in = '0;
               phase_a_in = 1'b1;
               found_in = 1'b0;
               mb_in = req_if.range_offset;
               me_in = req_if.range_offset + req_if.range_size;
               res_status_in = ST_OK;
               res_hit_in = 1'b0;
               res_bytes_in = '0;
               state_in = S_SCAN_RD;
               case (req_if.opcode)
                  OP_MARK: begin
                     if (!cfg.context_valid) begin
                        res_status_in = ST_INVALID_CTX;
                        state_in = S_RESP;
                     end else if (req_blk_bad || req_if.range_offset > req_bsize
                                  || req_if.range_size > req_bsize - req_if.range_offset) begin
                        res_status_in = ST_OUT_OF_RANGE;
                        state_in = S_RESP;
                     end else if (req_if.range_size == '0) begin
                        state_in = S_RESP;
                     end
                  end
                  OP_CONTAINS: begin
                     if (req_if.range_size == '0) begin
                        res_hit_in = 1'b1;
                        state_in = S_RESP;
                     end else if (req_blk_bad) begin
                        res_status_in = ST_OUT_OF_RANGE;
                        state_in = S_RESP;
                     end
                  end
                  OP_CONTIG: begin
                     if (!cfg.context_valid) begin
                        res_status_in = ST_INVALID_CTX;
                        state_in = S_RESP;
                     end else if (req_blk_bad || req_if.range_offset > req_bsize) begin
                        res_status_in = ST_OUT_OF_RANGE;
                        state_in = S_RESP;
                     end
                  end
                  default: begin
                     total_in = '0;
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_SCAN_RD: begin
            if (idx_ff >= total_ff) begin
               state_in = S_DECIDE;
            end else begin
               rd_en = 1'b1;
               state_in = S_SCAN_EV;
            end
         end
         S_SCAN_EV: begin
            state_in = S_SCAN_RD;
            if (op_ff == OP_MARK) begin
               if (phase_a_ff && (rd_data.blk < blk_ff
                   || (rd_data.blk == blk_ff && rd_data.last < mb_ff))) begin
                  idx_in = idx_ff + CW'(1);
               end else begin
                  if (phase_a_ff) begin
                     first_in = idx_ff;
                     phase_a_in = 1'b0;
                  end
                  if (rd_data.blk == blk_ff && rd_data.first <= me_ff) begin
                     if (rd_data.first < mb_ff) begin
                        mb_in = rd_data.first;
                     end
                     if (rd_data.last > me_ff) begin
                        me_in = rd_data.last;
                     end
                     merged_in = merged_ff + CW'(1);
                     idx_in = idx_ff + CW'(1);
                  end else begin
                     state_in = S_DECIDE;
                  end
               end
            end else begin
               if (rd_data.blk < blk_ff) begin
                  idx_in = idx_ff + CW'(1);
               end else if (rd_data.blk == blk_ff && rd_data.first <= off_ff) begin
                  found_in = 1'b1;
                  cov_end_in = rd_data.last;
                  idx_in = idx_ff + CW'(1);
               end else begin
                  state_in = S_DECIDE;
               end
            end
         end
         S_DECIDE: begin
            state_in = S_RESP;
            case (op_ff)
               OP_CONTAINS: begin
                  res_hit_in = found_ff && off_ff <= cov_end_ff
                               && size_ff <= cov_end_ff - off_ff;
               end
               OP_CONTIG: begin
                  if (!found_ff || off_ff >= cov_end_ff) begin
                     res_status_in = ST_UNMATERIALIZED;
                  end else begin
                     res_bytes_in = cov_end_ff - off_ff;
                  end
               end
               OP_MARK: begin
                  first_in = first_eff;
                  if (merged_ff != '0) begin
                     // keep the first merged entry, close the gap above it
                     wr_en = 1'b1;
                     wr_addr = first_eff[AW-1:0];
                     wr_data = '{blk: blk_ff, first: mb_ff, last: me_ff};
                     idx_in = first_eff + CW'(1);
                     state_in = S_DN_RD;
                  end else if (32'(total_ff) >= 32'(cfg.max_intervals)
                               || 32'(total_ff) >= DEPTH) begin
                     res_status_in = ST_CAPACITY;
                  end else begin
                     idx_in = total_ff;
                     state_in = S_UP_RD;
                  end
               end
               default: begin
               end
            endcase
         end
         S_DN_RD: begin
            if (src_idx < {1'b0, total_ff}) begin
               rd_en = 1'b1;
               rd_addr = src_idx[AW-1:0];
               state_in = S_DN_WR;
            end else begin
               total_in = total_ff - k_cnt;
               state_in = S_RESP;
            end
         end
         S_DN_WR: begin
            wr_en = 1'b1;
            idx_in = idx_ff + CW'(1);
            state_in = S_DN_RD;
         end
         S_UP_RD: begin
            if (idx_ff > first_ff) begin
               rd_en = 1'b1;
               rd_addr = AW'(idx_ff - CW'(1));
               state_in = S_UP_WR;
            end else begin
               wr_en = 1'b1;
               wr_addr = first_ff[AW-1:0];
               wr_data = '{blk: blk_ff, first: mb_ff, last: me_ff};
               total_in = total_ff + CW'(1);
               state_in = S_RESP;
            end
         end
         S_UP_WR: begin
            wr_en = 1'b1;
            idx_in = idx_ff - CW'(1);
            state_in = S_UP_RD;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               out_status_in = res_status_ff;
               out_hit_in = res_hit_ff;
               out_bytes_in = res_bytes_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         total_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      blk_ff <= blk_in;
      off_ff <= off_in;
      size_ff <= size_in;
      idx_ff <= idx_in;
      first_ff <= first_in;
      merged_ff <= merged_in;
      phase_a_ff <= phase_a_in;
      mb_ff <= mb_in;
      me_ff <= me_in;
      found_ff <= found_in;
      cov_end_ff <= cov_end_in;
      res_status_ff <= res_status_in;
      res_hit_ff <= res_hit_in;
      res_bytes_ff <= res_bytes_in;
      out_status_ff <= out_status_in;
      out_hit_ff <= out_hit_in;
      out_bytes_ff <= out_bytes_in;
   end

   `CIS_ASSERT_IMPL(a_total_bound, 1'b1, 32'(total_ff) <= DEPTH)
   `CIS_ASSERT_IMPL(a_no_same_entry, rd_en && wr_en, rd_addr != wr_addr)
   `CIS_ASSERT_NEXT(a_clear_empties, accept && req_if.opcode == OP_CLEAR, total_ff == '0)
endmodule
`default_nettype wire

### rtl/coalescing_interval_set_top.sv
// Interval set: keeps sorted, disjoint [begin, end) byte ranges per memory block in one
// shared table memory, and answers mark, contains, contiguous and clear requests, one
// result item per request item. Items are handled one at a time. A query walks the
// table from entry zero up to the covering interval, each entry read taking a memory
// read state and an evaluate state. A mark scans the same way, then moves the entries
// behind the merge or insertion point one at a time over the single read port, each
// through a read state and a write state. The table needs no clearing after reset:
// only entries below the count are ever read. Configuration goes over the apb port;
// the user must write it only while the block is idle, which the block itself does
// not enforce. A write never alters the table.
`default_nettype none
module coalescing_interval_set_top
   import cis_pkg::*;
#(
   parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
   parameter int BLOCKS = DEF_BLOCKS
) (
   input  wire logic              clock,
   input  wire logic              reset,
   cis_req_if.sink                req_if,
   cis_rsp_if.source              rsp_if,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CSR_AW-1:0] csr_paddr,
   input  wire logic [31:0]       csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);
   // table address and entry count widths
   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   cfg_type          cfg;
   logic             rd_en;
   logic [AW-1:0]    rd_addr;
   entry_type        rd_data;
   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   entry_type        wr_data;

   // register file
   cis_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // interval table memory, one read and one write port
   cis_table #(
      .DEPTH (TABLE_DEPTH),
      .AW    (AW)
   ) u_table (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   // sequencer: scan, merge, shift and result register
   cis_ctrl #(
      .DEPTH  (TABLE_DEPTH),
      .BLOCKS (BLOCKS),
      .AW     (AW),
      .CW     (CW)
   ) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .req_if  (req_if),
      .rsp_if  (rsp_if),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );
endmodule
`default_nettype wire
